// File: src/brb_pkg.sv
`timescale 1ns / 1ps

package brb_pkg;

   // Ring geometry and field widths.
   localparam int DEPTH     = 256;
   localparam int MAX_CHUNK = 8;
   localparam int PTR_W     = $clog2(DEPTH);
   localparam int CAP_W     = 9;
   localparam int LEN_W     = 4;
   localparam int DATA_W    = 64;
   localparam int CNT_W     = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;

   // Operation carried in the kind field of a request.
   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_PEEK  = 2'd2,
      KIND_FLUSH = 2'd3
   } kind_type;

   // What the datapath decided to do with the latched request.
   typedef enum logic [2:0] {
      PLAN_CLEAR,
      PLAN_REFUSE,
      PLAN_OVERFLOW,
      PLAN_WRITE,
      PLAN_READ
   } plan_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_WRITE,
      ST_READ,
      ST_READ_TAIL,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic decide;
      logic step_write;
      logic step_read;
      logic commit;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      plan_type plan;
      logic     last;
      logic     out_free;
   } status_type;

endpackage

// File: src/brb_ram.sv
`timescale 1ns / 1ps

module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port: write or registered read at one address per cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/brb_ctrl.sv
`timescale 1ns / 1ps

module brb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  brb_pkg::status_type status,
   output brb_pkg::cmd_type    cmd,
   output logic                idle
);
   import brb_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      idle     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            case (status.plan)
               PLAN_WRITE: state_in = ST_WRITE;
               PLAN_READ:  state_in = ST_READ;
               default:    state_in = ST_FINISH;
            endcase
         end
         ST_WRITE: begin
            cmd.step_write = 1'b1;
            if (status.last) begin
               cmd.commit = 1'b1;
               state_in   = ST_FINISH;
            end
         end
         ST_READ: begin
            cmd.step_read = 1'b1;
            if (status.last) begin
               state_in = ST_READ_TAIL;
            end
         end
         ST_READ_TAIL: begin
            // The last byte arrives from memory on this edge.
            cmd.commit = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: src/brb_datapath.sv
`timescale 1ns / 1ps

module brb_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  brb_pkg::cmd_type           cmd,
   output brb_pkg::status_type        status,
   input  logic [1:0]                 req_kind,
   input  logic [brb_pkg::LEN_W-1:0]  req_length,
   input  logic [brb_pkg::DATA_W-1:0] req_payload,
   input  logic                       csr_write,
   input  logic [brb_pkg::CAP_W-1:0]  csr_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_ok,
   output logic [brb_pkg::DATA_W-1:0] rsp_read_data,
   output logic [brb_pkg::CAP_W-1:0]  rsp_fill_count,
   output logic [brb_pkg::CAP_W-1:0]  rsp_free_space,
   output logic                       rsp_is_empty,
   output logic                       rsp_is_full,
   output logic                       rsp_overflowed
);
   import brb_pkg::*;

   // Latched request.
   kind_type           kind_ff, kind_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [DATA_W-1:0]  payload_ff, payload_in;

   // Ring state.
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CAP_W-1:0]   fill_ff, fill_in;
   logic               ovf_ff, ovf_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;

   // Per-item walk through the ring.
   logic [PTR_W-1:0]   walk_ff, walk_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   byte_idx_ff, byte_idx_in;
   logic               pend_ff, pend_in;
   logic [DATA_W-1:0]  data_ff, data_in;
   logic               ok_ff, ok_in;

   // Output register.
   logic               out_valid_ff, out_valid_in;
   logic               out_ok_ff;
   logic [DATA_W-1:0]  out_data_ff;
   logic [CAP_W-1:0]   out_fill_ff;
   logic [CAP_W-1:0]   out_free_ff;
   logic               out_empty_ff;
   logic               out_full_ff;
   logic               out_ovf_ff;

   plan_type           plan;
   logic [PTR_W-1:0]   walk_next;
   logic [CAP_W-1:0]   free_now;
   logic [CAP_W-1:0]   len_ext;
   logic               len_ok;
   logic [CAP_W-1:0]   cap_eff;
   logic [CAP_W-1:0]   ring_span;
   logic [7:0]         ram_rdata;

   brb_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (cmd.step_write),
      .addr  (walk_ff),
      .wdata (payload_ff[7:0]),
      .rdata (ram_rdata)
   );

   // Pointer advance with wrap at the capacity.
   assign walk_next = ((CAP_W'(walk_ff) + 1'b1) >= cap_ff) ? '0 : walk_ff + 1'b1;

   assign free_now = cap_ff - fill_ff;
   assign len_ext  = CAP_W'(len_ff);
   assign len_ok   = (len_ff != '0) && (32'(len_ff) <= MAX_CHUNK);

   // A capacity of zero acts as one, anything past the ring depth as the depth.
   always_comb begin
      if (csr_value == '0) begin
         cap_eff = CAP_W'(1);
      end else if (32'(csr_value) > DEPTH) begin
         cap_eff = CAP_W'(DEPTH);
      end else begin
         cap_eff = csr_value;
      end
   end

   // Decision for the latched request.
   always_comb begin
      plan = PLAN_REFUSE;
      if (kind_ff == KIND_FLUSH) begin
         plan = PLAN_CLEAR;
      end else if (len_ok) begin
         if (kind_ff == KIND_WRITE) begin
            plan = (len_ext > free_now) ? PLAN_OVERFLOW : PLAN_WRITE;
         end else if (len_ext <= fill_ff) begin
            plan = PLAN_READ;
         end
      end
   end

   assign status = '{plan:     plan,
                     last:     (LEN_W'(cnt_ff) == (len_ff - 1'b1)),
                     out_free: (!out_valid_ff || rsp_ready)};

   // Next values of the working registers.
   always_comb begin
      kind_in     = kind_ff;
      len_in      = len_ff;
      payload_in  = payload_ff;
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      fill_in     = fill_ff;
      ovf_in      = ovf_ff;
      cap_in      = cap_ff;
      walk_in     = walk_ff;
      cnt_in      = cnt_ff;
      byte_idx_in = byte_idx_ff;
      data_in     = data_ff;
      ok_in       = ok_ff;
      pend_in     = cmd.step_read;

      if (cmd.load) begin
         kind_in    = kind_type'(req_kind);
         len_in     = req_length;
         payload_in = req_payload;
      end

      if (cmd.decide) begin
         walk_in     = (kind_ff == KIND_WRITE) ? wr_ptr_ff : rd_ptr_ff;
         cnt_in      = '0;
         byte_idx_in = '0;
         data_in     = '0;
         ok_in       = (plan == PLAN_CLEAR);
         if (plan == PLAN_CLEAR) begin
            rd_ptr_in = '0;
            wr_ptr_in = '0;
            fill_in   = '0;
            ovf_in    = 1'b0;
         end
         if (plan == PLAN_OVERFLOW) begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.step_write || cmd.step_read) begin
         walk_in = walk_next;
         cnt_in  = cnt_ff + 1'b1;
      end
      if (cmd.step_write) begin
         payload_in = payload_ff >> 8;
      end

      // Read data comes in the cycle after its address is presented.
      if (pend_ff) begin
         data_in[byte_idx_ff*8 +: 8] = ram_rdata;
         byte_idx_in                 = byte_idx_ff + 1'b1;
      end

      if (cmd.commit) begin
         ok_in = 1'b1;
         if (kind_ff == KIND_WRITE) begin
            wr_ptr_in = walk_next;
            fill_in   = fill_ff + len_ext;
         end else if (kind_ff == KIND_READ) begin
            rd_ptr_in = walk_ff;
            fill_in   = fill_ff - len_ext;
         end
      end

      // A capacity write empties the ring.
      if (csr_write) begin
         cap_in    = cap_eff;
         rd_ptr_in = '0;
         wr_ptr_in = '0;
         fill_in   = '0;
         ovf_in    = 1'b0;
      end
   end

   // Output register valid: set when a result is loaded, cleared by its transfer.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         cap_ff       <= CAP_W'(DEPTH);
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         cap_ff       <= cap_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      len_ff      <= len_in;
      payload_ff  <= payload_in;
      walk_ff     <= walk_in;
      cnt_ff      <= cnt_in;
      byte_idx_ff <= byte_idx_in;
      data_ff     <= data_in;
      ok_ff       <= ok_in;
      if (cmd.emit) begin
         out_ok_ff    <= ok_ff;
         out_data_ff  <= data_ff;
         out_fill_ff  <= fill_ff;
         out_free_ff  <= cap_ff - fill_ff;
         out_empty_ff <= (fill_ff == '0);
         out_full_ff  <= (fill_ff >= cap_ff);
         out_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_ok         = out_ok_ff;
   assign rsp_read_data  = out_data_ff;
   assign rsp_fill_count = out_fill_ff;
   assign rsp_free_space = out_free_ff;
   assign rsp_is_empty   = out_empty_ff;
   assign rsp_is_full    = out_full_ff;
   assign rsp_overflowed = out_ovf_ff;

   // Distance from the read pointer to the write pointer around the ring.
   assign ring_span = (wr_ptr_ff >= rd_ptr_ff) ?
                      CAP_W'(wr_ptr_ff) - CAP_W'(rd_ptr_ff) :
                      CAP_W'(wr_ptr_ff) + cap_ff - CAP_W'(rd_ptr_ff);

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cap_ff)
      else $error("fill level exceeds capacity");

   a_rd_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      CAP_W'(rd_ptr_ff) < cap_ff)
      else $error("read pointer beyond capacity");

   a_wr_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      CAP_W'(wr_ptr_ff) < cap_ff)
      else $error("write pointer beyond capacity");

   a_ring_consistent: assert property (@(posedge clock) disable iff (reset)
      (ring_span == fill_ff) || ((ring_span == '0) && (fill_ff == cap_ff)))
      else $error("pointers disagree with fill level");

endmodule

// File: src/byte_ring_buffer_chunked_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Transfer fields
// req      in         tuser: kind; tdata: length, payload
// rsp      out        tdata: ok, read_data, fill_count, free_space, is_empty,
//                            is_full, overflowed
// csr      in         data: capacity (also empties the ring)
//
// One request at a time. Each is loaded, decided and finished; a write adds a
// step per byte, a read or peek a step per byte and a tail step: the single-port
// byte memory moves one byte per cycle. A request may be accepted while the
// previous result still waits in the output register; a stalled result holds
// only the finishing step. Reset is synchronous and sets the capacity to 256
// with the ring empty; no clearing pass of the memory is needed.

module byte_ring_buffer_chunked_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // length[3:0], payload[67:4], zero[71:68]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // ok[0], read_data[64:1], fill_count[73:65],
                                    // free_space[82:74], is_empty[83], is_full[84],
                                    // overflowed[85], zero[87:86]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data     // capacity[8:0]
);
   import brb_pkg::*;

   cmd_type           cmd;
   status_type        status;
   logic              idle;
   logic              rsp_ok;
   logic [DATA_W-1:0] rsp_read_data;
   logic [CAP_W-1:0]  rsp_fill_count;
   logic [CAP_W-1:0]  rsp_free_space;
   logic              rsp_is_empty;
   logic              rsp_is_full;
   logic              rsp_overflowed;

   // Both input channels are taken only between items.
   assign req_tready = idle;
   assign csr_ready  = idle;

   brb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .cmd        (cmd),
      .idle       (idle)
   );

   brb_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_kind       (req_tuser),
      .req_length     (req_tdata[3:0]),
      .req_payload    (req_tdata[67:4]),
      .csr_write      (csr_valid && csr_ready),
      .csr_value      (csr_data),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_ok         (rsp_ok),
      .rsp_read_data  (rsp_read_data),
      .rsp_fill_count (rsp_fill_count),
      .rsp_free_space (rsp_free_space),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .rsp_overflowed (rsp_overflowed)
   );

   // Pack the result fields, lowest field first.
   assign rsp_tdata = {2'b00, rsp_overflowed, rsp_is_full, rsp_is_empty,
                       rsp_free_space, rsp_fill_count, rsp_read_data, rsp_ok};

endmodule
